>>> rtl/core/base64_stream_encoder_assert.svh
// Assertion macros shared by the base64 encoder RTL.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define B64E_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle implication, disabled while in reset.
`define B64E_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

>>> rtl/core/b64e_pkg.sv
// Types, constants and the alphabet function of the base64 stream encoder.
`default_nettype none
package b64e_pkg;

    localparam int          MAX_CHARS   = 5;
    localparam int          CNT_W       = $clog2(MAX_CHARS + 1);
    localparam int          QUEUE_DEPTH = 4;
    localparam logic [5:0]  GPL_RESET   = 6'd19;
    localparam logic [7:0]  LINE_FEED   = 8'h0A;
    localparam logic [7:0]  PAD_CHAR    = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
    } t_out_item;

    // All characters caused by one input byte, oldest in entry 0.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          count;
    } t_job;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/b64e_front.sv
// Front end: takes bytes, tracks group phase and line fill, builds character jobs.
`default_nettype none
module b64e_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [5:0]        i_cfg_data,
    input  wire logic              i_accept,
    input  wire b64e_pkg::t_in_item i_in,
    output b64e_pkg::t_job         o_job
);
    import b64e_pkg::*;

    logic [5:0] r_gpl;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    logic [5:0] r_gil,   n_gil;

    t_job       job;
    logic [2:0] n;
    logic       grp, closed;
    logic [5:0] gil_inc;
    logic [7:0] b;

    always_comb begin
        job     = '0;
        n       = '0;
        grp     = 1'b0;
        closed  = 1'b0;
        b       = i_in.data_byte;
        n_phase = r_phase;
        n_left  = r_left;
        n_gil   = r_gil;
        gil_inc = r_gil + 6'd1;

        case (r_phase)
            2'd1: begin
                job.chars[n] = b64_sym({r_left[1:0], b[7:4]}); n = n + 3'd1;
                n_left  = b[3:0];
                n_phase = 2'd2;
            end
            2'd2: begin
                job.chars[n] = b64_sym({r_left[3:0], b[7:6]}); n = n + 3'd1;
                job.chars[n] = b64_sym(b[5:0]);                n = n + 3'd1;
                n_left  = 4'd0;
                n_phase = 2'd0;
                grp     = 1'b1;
            end
            default: begin
                // phase 3 never occurs; handled as the start of a group
                job.chars[n] = b64_sym(b[7:2]); n = n + 3'd1;
                n_left  = {2'b00, b[1:0]};
                n_phase = 2'd1;
            end
        endcase

        // flush of a partial group on the last byte
        if (i_in.final_byte) begin
            if (n_phase == 2'd1) begin
                job.chars[n] = b64_sym({n_left[1:0], 4'b0000}); n = n + 3'd1;
                job.chars[n] = PAD_CHAR;                        n = n + 3'd1;
                job.chars[n] = PAD_CHAR;                        n = n + 3'd1;
                grp = 1'b1;
            end else if (n_phase == 2'd2) begin
                job.chars[n] = b64_sym({n_left[3:0], 2'b00}); n = n + 3'd1;
                job.chars[n] = PAD_CHAR;                      n = n + 3'd1;
                grp = 1'b1;
            end
        end

        if (grp) begin
            if (r_gpl != 6'd0 && gil_inc >= r_gpl) begin
                job.chars[n] = LINE_FEED; n = n + 3'd1;
                n_gil  = 6'd0;
                closed = 1'b1;
            end else begin
                n_gil = gil_inc;
            end
        end

        if (i_in.final_byte) begin
            if (!closed && r_gpl != 6'd0 && n_gil != 6'd0) begin
                job.chars[n] = LINE_FEED; n = n + 3'd1;
            end
            n_phase = 2'd0;
            n_left  = 4'd0;
            n_gil   = 6'd0;
        end

        job.count = CNT_W'(n);
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl   <= GPL_RESET;
            r_phase <= 2'd0;
            r_left  <= 4'd0;
            r_gil   <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                r_gpl <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_gil   <= n_gil;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/b64e_queue.sv
// Short job queue between the front end and the character serialiser.
`default_nettype none
`include "base64_stream_encoder_assert.svh"
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire b64e_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output b64e_pkg::t_job      o_job,
    output logic                o_empty
);
    import b64e_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `B64E_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `B64E_ASSERT_NOW(a_full_ptrs, i_clk, i_rst_n, o_full, r_wr == r_rd)
    `B64E_ASSERT_NXT(a_count_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + CW'(1))

endmodule
`default_nettype wire

>>> rtl/core/b64e_back.sv
// Back end: serialises queued jobs into characters with run_end, one per cycle while the output is popped.
`default_nettype none
`include "base64_stream_encoder_assert.svh"
module b64e_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire b64e_pkg::t_job i_job,
    input  wire logic           i_job_empty,
    output logic                o_job_pop,
    output b64e_pkg::t_out_item o_out,
    output logic                o_empty,
    input  wire logic           i_pop
);
    import b64e_pkg::*;

    t_job             r_job;
    logic [CNT_W-1:0] r_idx;
    logic             r_busy;
    t_out_item        r_out;
    logic             r_out_valid;

    logic out_free, last, job_take;

    assign out_free  = !r_out_valid || i_pop;
    assign last      = (r_idx == r_job.count - CNT_W'(1));
    // next job is fetched on the same edge as the last character of this one
    assign job_take  = !i_job_empty && (!r_busy || (out_free && last));
    assign o_job_pop = job_take;
    assign o_out     = r_out;
    assign o_empty   = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (out_free && r_busy) begin
            r_out.out_char <= r_job.chars[r_idx[2:0]];
            r_out.run_end  <= last;
        end
        if (job_take) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_busy;
            end
            if (job_take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_free && r_busy) begin
                r_idx <= r_idx + CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    `B64E_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, r_busy, r_idx < r_job.count)
    `B64E_ASSERT_NOW(a_job_size, i_clk, i_rst_n, job_take, i_job.count != '0 && i_job.count <= CNT_W'(MAX_CHARS))
    `B64E_ASSERT_NXT(a_char_loaded, i_clk, i_rst_n, out_free && r_busy, r_out_valid)

endmodule
`default_nettype wire

>>> rtl/core/base64_stream_encoder.sv
// Top level of the base64 stream encoder.
//
//  channel  | handshake          | payload                  | dir
//  ---------+--------------------+--------------------------+-----
//  bytes    | push / full        | i_in  (data_byte, final) | in
//  chars    | empty / pop        | o_out (out_char, run_end)| out
//  config   | i_cfg_we           | i_cfg_data (groups/line) | in
//
// A byte is taken in the cycle it is pushed while the job queue has room;
// it turns into 1 to 5 characters, delivered one per cycle by the serialiser
// while the output is popped, so the sustained rate is set by the character
// count. Reset is synchronous. A stalled output holds its character; the queue
// keeps taking bytes until it is full.
`default_nettype none
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [5:0]          i_cfg_data,
    input  wire logic                push,
    output logic                     full,
    input  wire b64e_pkg::t_in_item  i_in,
    output logic                     empty,
    input  wire logic                pop,
    output b64e_pkg::t_out_item      o_out
);
    import b64e_pkg::*;

    t_job q_in_job, q_out_job;
    logic q_full, q_empty, q_pop, accept;

    assign accept = push && !q_full;
    assign full   = q_full;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_in       (i_in),
        .o_job      (q_in_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_out_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .o_out       (o_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the base64 stream encoder: directed table, then random streams.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_ITEMS = 480;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0]  data;
        logic        fin;
        int          nchr;   // 0: take the characters from the predictor
        logic [39:0] text;
    } t_dir_row;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [5:0] i_cfg_data = '0;
    logic       push       = 1'b0;
    logic       pop        = 1'b0;
    logic       full;
    logic       empty;
    t_in_item   i_in       = '0;
    t_out_item  o_out;

    // predictor state
    logic [1:0] enc_phase   = '0;
    logic [3:0] enc_rest    = '0;
    logic [5:0] enc_groups  = '0;
    logic [5:0] line_groups = GPL_RESET;

    logic [7:0] step_chars[$];
    t_out_item  pending_chars[$];
    t_dir_row   dir_rows[$];

    int  mismatches  = 0;
    int  cycles      = 0;
    int  rand_sent   = 0;
    int  stream_left = 0;
    bit  tx_on       = 1'b0;
    bit  tx_idle     = 1'b1;
    bit  rx_quiet    = 1'b0;
    bit  hold_req    = 1'b0;

    base64_stream_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return ALPHABET[8*(63 - v) +: 8];
    endfunction

    // Counts a finished group; returns 1 if it closed the line.
    function automatic bit close_group();
        enc_groups = enc_groups + 6'd1;
        if (line_groups != 0 && enc_groups >= line_groups) begin
            step_chars.push_back(LINE_FEED);
            enc_groups = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void encode_byte(input t_in_item it);
        logic [7:0] b;
        bit         closed;
        b      = it.data_byte;
        closed = 1'b0;
        step_chars.delete();
        case (enc_phase)
            2'd1: begin
                step_chars.push_back(b64_char({enc_rest[1:0], b[7:4]}));
                enc_rest  = b[3:0];
                enc_phase = 2'd2;
            end
            2'd2: begin
                step_chars.push_back(b64_char({enc_rest, b[7:6]}));
                step_chars.push_back(b64_char(b[5:0]));
                enc_rest  = '0;
                enc_phase = 2'd0;
                closed    = close_group();
            end
            default: begin
                step_chars.push_back(b64_char(b[7:2]));
                enc_rest  = {2'b00, b[1:0]};
                enc_phase = 2'd1;
            end
        endcase
        if (it.final_byte) begin
            if (enc_phase == 2'd1) begin
                step_chars.push_back(b64_char({enc_rest[1:0], 4'b0000}));
                step_chars.push_back(PAD_CHAR);
                step_chars.push_back(PAD_CHAR);
                closed = close_group();
            end else if (enc_phase == 2'd2) begin
                step_chars.push_back(b64_char({enc_rest, 2'b00}));
                step_chars.push_back(PAD_CHAR);
                closed = close_group();
            end
            // closing line feed only for a line that is open and not just ended
            if (!closed && line_groups != 0 && enc_groups != 0) begin
                step_chars.push_back(LINE_FEED);
            end
            enc_phase  = '0;
            enc_rest   = '0;
            enc_groups = '0;
        end
    endfunction

    task automatic push_low();
        if (tx_on) begin
            push  <= 1'b0;
            tx_on = 1'b0;
        end
    endtask

    // Offers one request and waits for it to be taken; expectations are
    // queued at the falling edge before the accepting edge.
    task automatic put_byte(input t_in_item it, input int nchr, input logic [39:0] text);
        logic was_full;
        int   k;
        if (!tx_on) begin
            push  <= 1'b1;
            tx_on = 1'b1;
        end
        i_in <= it;
        do begin
            @(negedge i_clk);
            was_full = full;
            if (!was_full) begin
                encode_byte(it);
                if (nchr != 0) begin
                    step_chars.delete();
                    for (k = 0; k < nchr; k++) begin
                        step_chars.push_back(text[8*(nchr - 1 - k) +: 8]);
                    end
                end
                for (k = 0; k < step_chars.size(); k++) begin
                    pending_chars.push_back('{step_chars[k], k == step_chars.size() - 1});
                end
            end
            @(posedge i_clk);
        end while (was_full);
    endtask

    task automatic idle_tx();
        push_low();
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    task automatic drain();
        push_low();
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_line_groups(input logic [5:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        line_groups = v;
    endtask

    // Random streams: mostly short, now and then long enough to fill lines.
    task automatic feed_streams(input int count, input bit finals);
        t_in_item it;
        repeat (count) begin
            if (stream_left == 0) begin
                stream_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 130)
                                                           : $urandom_range(1, 12);
            end
            it.data_byte  = 8'($urandom_range(0, 255));
            it.final_byte = finals && (stream_left == 1);
            stream_left--;
            put_byte(it, 0, '0);
            rand_sent++;
            if (tx_idle && $urandom_range(0, 6) == 0) begin
                idle_tx();
            end
        end
    endtask

    // Result side: random stalls, a long hold-off on request, checks.
    initial begin : rx_side
        logic      was_empty;
        logic      was_pop;
        t_out_item seen;
        t_out_item want;
        int        stall;
        stall = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            was_empty = empty;
            was_pop   = pop;
            seen      = o_out;
            @(posedge i_clk);
            if (was_pop && !was_empty) begin
                if (pending_chars.size() == 0) begin
                    $error("character %h with no request pending", seen.out_char);
                    mismatches++;
                end else begin
                    want = pending_chars.pop_front();
                    if (seen.out_char !== want.out_char) begin
                        $error("out_char: expected %h, got %h", want.out_char, seen.out_char);
                        mismatches++;
                    end
                    if (seen.run_end !== want.run_end) begin
                        $error("run_end: expected %b, got %b", want.run_end, seen.run_end);
                        mismatches++;
                    end
                end
            end
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                stall = $urandom_range(1, 17) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : tx_side
        t_in_item it;
        // typed rows assume the reset line length and a fresh stream
        dir_rows.push_back('{8'h00, 1'b1, 5, "AA==\n"});
        dir_rows.push_back('{8'hFF, 1'b1, 5, "/w==\n"});
        dir_rows.push_back('{8'hFF, 1'b0, 1, "/"});
        dir_rows.push_back('{8'hFF, 1'b0, 1, "/"});
        dir_rows.push_back('{8'hFF, 1'b1, 3, "//\n"});
        dir_rows.push_back('{8'h4D, 1'b0, 1, "T"});
        dir_rows.push_back('{8'h61, 1'b0, 1, "W"});
        dir_rows.push_back('{8'h6E, 1'b1, 3, "Fu\n"});
        dir_rows.push_back('{8'h00, 1'b0, 1, "A"});
        dir_rows.push_back('{8'h80, 1'b1, 4, "IA=\n"});
        dir_rows.push_back('{8'hAA, 1'b0, 0, '0});
        dir_rows.push_back('{8'h55, 1'b0, 0, '0});
        dir_rows.push_back('{8'h0F, 1'b0, 0, '0});
        dir_rows.push_back('{8'hF0, 1'b1, 0, '0});
        dir_rows.push_back('{8'h01, 1'b0, 0, '0});
        dir_rows.push_back('{8'hFE, 1'b1, 0, '0});
        dir_rows.push_back('{8'h3C, 1'b0, 0, '0});
        dir_rows.push_back('{8'hC3, 1'b0, 0, '0});
        dir_rows.push_back('{8'h5A, 1'b1, 0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            it.data_byte  = dir_rows[r].data;
            it.final_byte = dir_rows[r].fin;
            put_byte(it, dir_rows[r].nchr, dir_rows[r].text);
            if ($urandom_range(0, 3) == 0) begin
                idle_tx();
            end
        end

        // a line feed after every group
        set_line_groups(6'd1);
        feed_streams(50, 1'b1);
        // no line feeds, one long stream so the group count wraps
        set_line_groups(6'd0);
        feed_streams(200, 1'b0);
        // longest line, left open
        set_line_groups(6'd63);
        feed_streams(100, 1'b0);
        // lowered mid-line: the next group must break the line at once
        set_line_groups(6'd5);
        feed_streams(40, 1'b1);
        // receiver holds off while the sender keeps offering
        set_line_groups(GPL_RESET);
        hold_req = 1'b1;
        feed_streams(40, 1'b1);

        while (rand_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       set_line_groups(6'd0);
                1:       set_line_groups(6'd63);
                default: set_line_groups(6'($urandom_range(1, 62)));
            endcase
            if (rand_sent >= RANDOM_ITEMS - 60) begin
                tx_idle  = 1'b0;
                rx_quiet = 1'b1;
            end else begin
                tx_idle  = ($urandom_range(0, 4) != 0);
                rx_quiet = ($urandom_range(0, 4) == 0);
            end
            feed_streams(30, 1'b1);
        end

        push_low();
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
